FILE: rtl/core/ifc_pkg.sv
// ----------------------------------------------------------------------------
// ifc_pkg: shared types and constants of the integer / float cast unit
// Operation codes and the integer width limit.
// ----------------------------------------------------------------------------
package ifc_pkg;

	localparam int unsigned MaxIntWidth = 64;

	typedef enum logic [3:0] {
		OP_TRUNC  = 4'd0,
		OP_SEXT   = 4'd1,
		OP_ZEXT   = 4'd2,
		OP_FPTRUNC = 4'd3,
		OP_FPEXT  = 4'd4,
		OP_FPTOUI = 4'd5,
		OP_FPTOSI = 4'd6,
		OP_UITOFP = 4'd7,
		OP_SITOFP = 4'd8
	} op_t;

endpackage

FILE: rtl/core/int_float_cast_unit.sv
// ----------------------------------------------------------------------------
// int_float_cast_unit: scalar integer / IEEE-754 cast unit
// Integer width casts, single/double conversion, float-to-int and int-to-float.
// ----------------------------------------------------------------------------
// Done is the start bit carried through the stage 1 to stage 4 valid registers.
// Throughput: one transaction per cycle; busy is tied low because every
// stage moves each cycle and the receiver cannot stall the result port.
// Reset clears only the stage valid bits; payload registers are not reset.
// The depth is set by the leading-one search and rounding shifts, which
// are cut across four register stages.
module int_float_cast_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [3:0]  operation,
	input  logic [63:0] operand_bits,
	input  logic [6:0]  src_width,
	input  logic [6:0]  dst_width,
	input  logic        src_is_double,
	input  logic        dst_is_double,
	output logic        done,
	output logic [63:0] result_bits,
	output logic        invalid
);
	import ifc_pkg::*;

	// Widths saturate into the range 1..MaxIntWidth.
	function automatic logic [6:0] fit_w(input logic [6:0] w);
		if (w == 7'd0) return 7'd1;
		if (w > 7'(MaxIntWidth)) return 7'(MaxIntWidth);
		return w;
	endfunction

	function automatic logic [63:0] wmask(input logic [6:0] w);
		return (w >= 7'd64) ? {64{1'b1}} : ((64'd1 << w[5:0]) - 64'd1);
	endfunction

	// Position of the highest set bit (0 for zero).
	function automatic logic [5:0] top_bit(input logic [63:0] v);
		logic [5:0] p;
		p = 6'd0;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) p = 6'(i);
		end
		return p;
	endfunction

	// Round-to-nearest-even right shift by s (1..63).
	function automatic logic [63:0] shr_rne(input logic [63:0] v, input logic [5:0] s);
		logic [63:0] keep, rem, half;
		keep = v >> s;
		rem = v & ((64'd1 << s) - 64'd1);
		half = 64'd1 << (s - 6'd1);
		if (rem > half || (rem == half && keep[0])) keep = keep + 64'd1;
		return keep;
	endfunction

	// Exact single to double widening.
	function automatic logic [63:0] s2d(input logic [31:0] x);
		logic [63:0] sg;
		logic [7:0] e;
		logic [22:0] f;
		logic [5:0] p;
		logic [63:0] fs;
		sg = {x[31], 63'd0};
		e = x[30:23];
		f = x[22:0];
		p = top_bit({41'd0, f});
		fs = ({41'd0, f} << (6'd52 - p));
		if (e == 8'hFF) begin
			if (f == 23'd0) return sg | {1'b0, 11'h7FF, 52'd0};
			// The NaN is made quiet; its payload keeps its leading bits.
			return sg | {1'b0, 11'h7FF, 1'b1, f[21:0], 29'd0};
		end
		if (e == 8'd0) begin
			if (f == 23'd0) return sg;
			return sg | {1'b0, 11'(11'd874 + {5'd0, p}), fs[51:0]};
		end
		return sg | {1'b0, 11'({3'd0, e} + 11'd896), f, 29'd0};
	endfunction

	// Double to single, round to nearest even.
	function automatic logic [31:0] d2s(input logic [63:0] x);
		logic [31:0] sg;
		logic [10:0] e;
		logic [51:0] f;
		logic [63:0] mant, keep;
		logic signed [12:0] ex;
		logic [12:0] sh;
		sg = {x[63], 31'd0};
		e = x[62:52];
		f = x[51:0];
		mant = {11'd0, 1'b1, f};
		ex = $signed({2'b00, e}) - 13'sd1023;
		if (e == 11'h7FF) begin
			if (f == 52'd0) return sg | 32'h7F800000;
			return sg | 32'h7FC00000 | {9'd0, f[51:29]};
		end
		if (e == 11'd0) return sg;
		if (ex > 13'sd127) return sg | 32'h7F800000;
		if (ex >= -13'sd126) begin
			keep = shr_rne(mant, 6'd29);
			if (keep == (64'd1 << 24)) begin
				keep = keep >> 1;
				ex = ex + 13'sd1;
			end
			if (ex > 13'sd127) return sg | 32'h7F800000;
			return sg | {1'b0, 8'(ex + 13'sd127), keep[22:0]};
		end
		sh = 13'(-ex - 13'sd97);
		if (sh > 13'd60) return sg;
		keep = shr_rne(mant, sh[5:0]);
		return sg | keep[31:0];
	endfunction

	// Stage 1: decode, integer casts, int-to-float source magnitude and sign.
	logic        v_s1;
	logic [3:0]  op_s1;
	logic [63:0] x_s1, src_s1, ires_s1;
	logic [6:0]  dw_s1;
	logic        sd_s1, dd_s1, neg_s1;
	// Stage 2: float source as double, int magnitude leading one.
	logic        v_s2;
	logic [3:0]  op_s2;
	logic [63:0] x_s2, d_s2, mag_s2, ires_s2;
	logic [6:0]  dw_s2;
	logic        sd_s2, dd_s2, neg_s2;
	logic [5:0]  p_s2;
	// Stage 3: result select: int-to-double, float-to-int, float and integer casts.
	logic        v_s3;
	logic [3:0]  op_s3;
	logic [63:0] r_s3;
	logic        bad_s3, dd_s3;
	// Stage 4: output register.
	logic        v_s4;
	logic [63:0] r_s4;
	logic        bad_s4;

	assign busy = 1'b0;
	assign done = v_s4;
	assign result_bits = r_s4;
	assign invalid = bad_s4;

	logic [6:0]  sw_c, dw_c;
	logic [5:0]  sb_c;
	logic [63:0] src_c, sx_c;
	always_comb begin
		sw_c = fit_w(src_width);
		dw_c = fit_w(dst_width);
		sb_c = 6'(sw_c - 7'd1);
		src_c = operand_bits & wmask(sw_c);
		sx_c = src_c;
		if (src_c[sb_c]) sx_c = src_c | ~wmask(sw_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		op_s1 <= operation;
		x_s1 <= operand_bits;
		dw_s1 <= dw_c;
		sd_s1 <= src_is_double;
		dd_s1 <= dst_is_double;
		ires_s1 <= ((operation == OP_SEXT) ? sx_c : src_c) & wmask(dw_c);
		if (operation == OP_SITOFP && sx_c[63]) begin
			src_s1 <= 64'd0 - sx_c;
			neg_s1 <= 1'b1;
		end else begin
			src_s1 <= src_c;
			neg_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		op_s2 <= op_s1;
		x_s2 <= x_s1;
		dw_s2 <= dw_s1;
		sd_s2 <= sd_s1;
		dd_s2 <= dd_s1;
		neg_s2 <= neg_s1;
		ires_s2 <= ires_s1;
		mag_s2 <= src_s1;
		p_s2 <= top_bit(src_s1);
		d_s2 <= sd_s1 ? x_s1 : s2d(x_s1[31:0]);
	end

	// Stage 3 combinational work.
	logic [63:0] r_c, keep_c, mg_c, lim_c, mant_c;
	logic        bad_c;
	logic [6:0]  p_c;
	logic signed [12:0] ex_c;
	always_comb begin
		r_c = 64'd0;
		bad_c = 1'b0;
		keep_c = 64'd0;
		mg_c = 64'd0;
		p_c = {1'b0, p_s2};
		mant_c = {11'd0, 1'b1, d_s2[51:0]};
		ex_c = $signed({2'b00, d_s2[62:52]}) - 13'sd1023;
		lim_c = 64'd1 << (dw_s2 - 7'd1);
		case (op_s2)
			OP_TRUNC, OP_SEXT, OP_ZEXT: r_c = ires_s2;
			OP_FPTRUNC, OP_FPEXT: begin
				if (sd_s2 == dd_s2) r_c = sd_s2 ? x_s2 : {32'd0, x_s2[31:0]};
				else if (sd_s2) r_c = {32'd0, d2s(x_s2)};
				else r_c = d_s2;
			end
			OP_FPTOUI, OP_FPTOSI: begin
				if (d_s2[62:52] == 11'h7FF || ex_c >= 13'sd64) bad_c = 1'b1;
				else begin
					if (ex_c < 13'sd0) mg_c = 64'd0;
					else if (ex_c <= 13'sd52) mg_c = mant_c >> 6'(13'sd52 - ex_c);
					else mg_c = mant_c << 6'(ex_c - 13'sd52);
					if (op_s2 == OP_FPTOUI) begin
						if ((d_s2[63] && mg_c != 64'd0) || mg_c > wmask(dw_s2)) bad_c = 1'b1;
						else r_c = mg_c;
					end else begin
						if (d_s2[63] ? (mg_c > lim_c) : (mg_c >= lim_c)) bad_c = 1'b1;
						else r_c = (d_s2[63] ? 64'd0 - mg_c : mg_c) & wmask(dw_s2);
					end
				end
			end
			OP_UITOFP, OP_SITOFP: begin
				if (mag_s2 != 64'd0) begin
					if (p_s2 <= 6'd52) keep_c = mag_s2 << (6'd52 - p_s2);
					else begin
						keep_c = shr_rne(mag_s2, p_s2 - 6'd52);
						// Rounding can carry into the next power of two, up to 2^64.
						if (keep_c == (64'd1 << 53)) begin
							keep_c = keep_c >> 1;
							p_c = {1'b0, p_s2} + 7'd1;
						end
					end
					r_c = {neg_s2, 11'(11'd1023 + {4'd0, p_c}), keep_c[51:0]};
				end
			end
			default: r_c = 64'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		op_s3 <= op_s2;
		r_s3 <= r_c;
		bad_s3 <= bad_c;
		dd_s3 <= dd_s2;
	end

	// Stage 4: second rounding to single for int-to-float.
	always_ff @(posedge clk) begin
		bad_s4 <= bad_s3;
		if ((op_s3 == OP_UITOFP || op_s3 == OP_SITOFP) && !dd_s3)
			r_s4 <= {32'd0, d2s(r_s3)};
		else
			r_s4 <= r_s3;
	end

endmodule
